// ----- sv/qurt_pkg.sv -----
// Shared types, constants and codes for the quad UART register block.
package qurt_pkg;

  localparam int unsigned UNITS = 4;
  localparam int unsigned UNIT_W = 2;
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned TX_DRAIN_PER_TICK = 16;
  localparam int unsigned BACKLOG_W = 16;
  localparam int unsigned ADDR_W = 24;
  localparam int unsigned WINDOW_BYTES = 32;
  localparam int unsigned IRQ_LINES = 4;
  localparam int unsigned CFG_ADDR_W = 5;

  localparam logic [BACKLOG_W-1:0] BACKLOG_MAX = {BACKLOG_W{1'b1}};
  localparam logic [BACKLOG_W-1:0] TX_DRAIN = BACKLOG_W'(TX_DRAIN_PER_TICK);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  localparam logic [7:0] IIR_RX_READY = 8'hc4;
  localparam logic [7:0] IIR_TX_READY = 8'hc2;
  localparam logic [7:0] IIR_NONE = 8'hc1;
  localparam logic [7:0] LSR_RESET = 8'h60;
  localparam logic [7:0] LSR_THRE_TEMT = 8'h60;
  localparam logic [7:0] LSR_CLR_OVERRUN = 8'hfd;
  localparam logic [7:0] LSR_CLR_DR = 8'hfe;
  localparam logic [7:0] LSR_DR = 8'h01;
  localparam logic [7:0] LSR_OVERRUN = 8'h02;
  localparam logic [7:0] SCR_RESET = 8'hff;
  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned IER_RX_BIT = 0;
  localparam int unsigned IER_TX_BIT = 1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RX    = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OFS_DATA = 3'd0,
    OFS_IER  = 3'd1,
    OFS_IIR  = 3'd2,
    OFS_LCR  = 3'd3,
    OFS_MCR  = 3'd4,
    OFS_LSR  = 3'd5,
    OFS_MSR  = 3'd6,
    OFS_SCR  = 3'd7
  } ofs_e;

  typedef enum logic [2:0] {
    CFG_BASE = 3'd0,
    CFG_IRQ0 = 3'd1,
    CFG_IRQ1 = 3'd2,
    CFG_IRQ2 = 3'd3,
    CFG_IRQ3 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [IRQ_LINES-1:0][2:0] irq_line;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ier;
    logic [7:0] lcr;
    logic [7:0] mcr;
    logic [7:0] lsr;
    logic [7:0] scr;
    logic rx_pend;
    logic tx_pend;
    logic [BACKLOG_W-1:0] backlog;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [CNT_W-1:0] count;
  } unit_st_t;

  localparam unit_st_t UNIT_RESET = '{
    ier: 8'h00, lcr: 8'h00, mcr: 8'h00, lsr: LSR_RESET, scr: SCR_RESET,
    rx_pend: 1'b0, tx_pend: 1'b0, backlog: '0, head: '0, tail: '0, count: '0
  };

endpackage

// ----- sv/qurt_cfg_regs.sv -----
// APB configuration registers: window base and per-unit interrupt lines.
module qurt_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qurt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output qurt_pkg::cfg_t                  cfg_o
);

  qurt_pkg::cfg_t cfg_q, cfg_d;
  logic wr_en;
  qurt_pkg::cfg_idx_e idx;

  assign idx = qurt_pkg::cfg_idx_e'(paddr[qurt_pkg::CFG_ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        qurt_pkg::CFG_BASE: cfg_d.base = pwdata[qurt_pkg::ADDR_W-1:0];
        qurt_pkg::CFG_IRQ0: cfg_d.irq_line[0] = pwdata[2:0];
        qurt_pkg::CFG_IRQ1: cfg_d.irq_line[1] = pwdata[2:0];
        qurt_pkg::CFG_IRQ2: cfg_d.irq_line[2] = pwdata[2:0];
        qurt_pkg::CFG_IRQ3: cfg_d.irq_line[3] = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qurt_pkg::CFG_BASE: prdata = 32'(cfg_q.base);
      qurt_pkg::CFG_IRQ0: prdata = 32'(cfg_q.irq_line[0]);
      qurt_pkg::CFG_IRQ1: prdata = 32'(cfg_q.irq_line[1]);
      qurt_pkg::CFG_IRQ2: prdata = 32'(cfg_q.irq_line[2]);
      qurt_pkg::CFG_IRQ3: prdata = 32'(cfg_q.irq_line[3]);
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base <= '0;
      cfg_q.irq_line[0] <= 3'd7;
      cfg_q.irq_line[1] <= 3'd7;
      cfg_q.irq_line[2] <= 3'd7;
      cfg_q.irq_line[3] <= 3'd6;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- sv/qurt_state_mem.sv -----
// Per-unit register state memory with registered read and reset-value valid bits.
module qurt_state_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [qurt_pkg::UNIT_W-1:0]   raddr_i,
  output qurt_pkg::unit_st_t            rdata_o,
  input  logic                          we_i,
  input  logic [qurt_pkg::UNIT_W-1:0]   waddr_i,
  input  qurt_pkg::unit_st_t            wdata_i
);

  qurt_pkg::unit_st_t mem [qurt_pkg::UNITS];
  qurt_pkg::unit_st_t rdata_q;
  logic [qurt_pkg::UNITS-1:0] valid_q;
  logic rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : qurt_pkg::UNIT_RESET;

endmodule

// ----- sv/qurt_rx_fifo_mem.sv -----
// Receive FIFO storage for all units, one write and one registered read port.
module qurt_rx_fifo_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [qurt_pkg::UNIT_W-1:0]  wunit_i,
  input  logic [qurt_pkg::PTR_W-1:0]   wptr_i,
  input  logic [7:0]                   wdata_i,
  input  logic [qurt_pkg::UNIT_W-1:0]  runit_i,
  input  logic [qurt_pkg::PTR_W-1:0]   rptr_i,
  output logic [7:0]                   rdata_o
);

  logic [7:0] mem [qurt_pkg::UNITS][qurt_pkg::FIFO_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wunit_i][wptr_i] <= wdata_i;
    end
    rdata_q <= mem[runit_i][rptr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/quad_uart_register_block.sv -----
// Quad 16550-style UART register block: sequencer around the unit state memory.
//
// An item is taken while busy is low and start is high; its word appears on the
// result ports for one cycle with done_o high, and must be taken then. A bus
// access or received byte passes through a state memory read, then modify and
// write back; a read of offset 0 that pops a byte also passes through a FIFO
// read step, since the FIFO read needs the tail pointer from the state memory
// first. A tick walks the units one by one through the state memory. The next
// item can start in the cycle the result is shown. No clearing pass is needed
// after reset.
module quad_uart_register_block (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      kind_i,
  input  logic [qurt_pkg::ADDR_W-1:0]     addr_i,
  input  logic [7:0]                      write_data_i,
  input  logic [1:0]                      rx_unit_i,
  input  logic [7:0]                      rx_byte_i,
  output logic                            done_o,
  output logic                            selected_o,
  output logic [7:0]                      read_data_o,
  output logic [7:0]                      irq_lines_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qurt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_POP  = 4'b0100,
    S_TICK = 4'b1000
  } state_e;

  state_e state_q, state_d;
  qurt_pkg::cfg_t cfg;
  qurt_pkg::kind_e kind_q, kind_in;
  qurt_pkg::ofs_e ofs_q;
  logic [qurt_pkg::UNIT_W-1:0] unit_q, unit_in, st_raddr;
  logic [7:0] wdata_q, rxb_q;
  logic sel_q, sel_in, unit_ok;
  logic [7:0] irq_acc_q, irq_acc_d;
  logic accept;

  qurt_pkg::unit_st_t st, ns;
  logic st_we;
  logic [7:0] rdata_c, irq_c, line_bit;
  logic pop_c, fifo_we;
  logic [7:0] fifo_rdata;

  logic done_q, done_d;
  logic selected_q, selected_d;
  logic [7:0] read_data_q, read_data_d, irq_lines_q, irq_lines_d;
  logic [qurt_pkg::ADDR_W:0] addr_x, base_x;

  qurt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qurt_state_mem u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (st_raddr),
    .rdata_o (st),
    .we_i    (st_we),
    .waddr_i (unit_q),
    .wdata_i (ns)
  );

  qurt_rx_fifo_mem u_fifo (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .wunit_i (unit_q),
    .wptr_i  (st.head),
    .wdata_i (rxb_q),
    .runit_i (unit_q),
    .rptr_i  (st.tail),
    .rdata_o (fifo_rdata)
  );

  assign busy = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign kind_in = qurt_pkg::kind_e'(kind_i);

  assign addr_x = {1'b0, addr_i};
  assign base_x = {1'b0, cfg.base};
  assign sel_in = (kind_in == qurt_pkg::KIND_READ || kind_in == qurt_pkg::KIND_WRITE)
                  && (addr_x >= base_x)
                  && (addr_x < base_x + (qurt_pkg::ADDR_W + 1)'(qurt_pkg::WINDOW_BYTES));

  always_comb begin
    unique case (kind_in)
      qurt_pkg::KIND_RX:   unit_in = rx_unit_i;
      qurt_pkg::KIND_TICK: unit_in = '0;
      default:             unit_in = addr_i[4:3];
    endcase
  end

  always_comb begin
    if (state_q == S_TICK) begin
      st_raddr = unit_q + 1'b1;
    end else begin
      st_raddr = unit_in;
    end
  end

  assign unit_ok = ({1'b0, unit_q} < (qurt_pkg::UNIT_W + 1)'(qurt_pkg::UNITS));
  assign line_bit = 8'd1 << cfg.irq_line[unit_q];

  // modify one unit's state for the current item
  always_comb begin
    ns = st;
    rdata_c = 8'd0;
    irq_c = 8'd0;
    pop_c = 1'b0;
    fifo_we = 1'b0;
    unique case (kind_q)
      qurt_pkg::KIND_READ: begin
        if (sel_q && unit_ok) begin
          case (ofs_q)
            qurt_pkg::OFS_DATA: begin
              if (st.count != '0) begin
                pop_c = 1'b1;
                ns.tail = (st.tail == qurt_pkg::PTR_LAST) ? '0 : st.tail + 1'b1;
                ns.count = st.count - 1'b1;
              end
              if (ns.count == '0) begin
                ns.lsr = st.lsr & qurt_pkg::LSR_CLR_DR;
              end
            end
            qurt_pkg::OFS_IER: rdata_c = st.ier;
            qurt_pkg::OFS_IIR: begin
              if (st.rx_pend) begin
                rdata_c = qurt_pkg::IIR_RX_READY;
                ns.rx_pend = 1'b0;
              end else if (st.tx_pend) begin
                rdata_c = qurt_pkg::IIR_TX_READY;
                ns.tx_pend = 1'b0;
              end else begin
                rdata_c = qurt_pkg::IIR_NONE;
              end
            end
            qurt_pkg::OFS_LCR: rdata_c = st.lcr;
            qurt_pkg::OFS_MCR: rdata_c = st.mcr;
            qurt_pkg::OFS_LSR: rdata_c = st.lsr;
            qurt_pkg::OFS_MSR: rdata_c = 8'd0;
            default:           rdata_c = st.scr;
          endcase
        end
      end
      qurt_pkg::KIND_WRITE: begin
        if (sel_q && unit_ok) begin
          case (ofs_q)
            qurt_pkg::OFS_DATA: begin
              if (!st.lcr[qurt_pkg::LCR_DLAB_BIT] && st.ier[qurt_pkg::IER_TX_BIT]) begin
                if (st.backlog != qurt_pkg::BACKLOG_MAX) begin
                  ns.backlog = st.backlog + 1'b1;
                end
                ns.lsr = st.lsr & ~qurt_pkg::LSR_THRE_TEMT;
              end
            end
            qurt_pkg::OFS_IER: begin
              if (!st.lcr[qurt_pkg::LCR_DLAB_BIT]) begin
                ns.ier = wdata_q;
              end
            end
            qurt_pkg::OFS_LCR: ns.lcr = wdata_q;
            qurt_pkg::OFS_MCR: ns.mcr = wdata_q;
            qurt_pkg::OFS_SCR: ns.scr = wdata_q;
            default: ;
          endcase
        end
      end
      qurt_pkg::KIND_RX: begin
        if (unit_ok) begin
          if (st.count >= qurt_pkg::CNT_FULL) begin
            ns.lsr = st.lsr | qurt_pkg::LSR_OVERRUN;
          end else begin
            ns.lsr = (st.lsr & qurt_pkg::LSR_CLR_OVERRUN) | qurt_pkg::LSR_DR;
            fifo_we = (state_q == S_MOD);
            ns.head = (st.head == qurt_pkg::PTR_LAST) ? '0 : st.head + 1'b1;
            ns.count = st.count + 1'b1;
          end
          if (st.ier[qurt_pkg::IER_RX_BIT]) begin
            ns.rx_pend = 1'b1;
            irq_c = line_bit;
          end
        end
      end
      default: begin
        if (unit_ok && st.backlog != '0) begin
          ns.backlog = (st.backlog > qurt_pkg::TX_DRAIN) ? st.backlog - qurt_pkg::TX_DRAIN
                                                         : '0;
          if (ns.backlog == '0) begin
            ns.tx_pend = 1'b1;
            ns.lsr = st.lsr | qurt_pkg::LSR_THRE_TEMT;
            irq_c = line_bit;
          end
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    st_we = 1'b0;
    irq_acc_d = irq_acc_q;
    done_d = 1'b0;
    selected_d = selected_q;
    read_data_d = read_data_q;
    irq_lines_d = irq_lines_q;
    unique case (state_q)
      S_IDLE: begin
        irq_acc_d = 8'd0;
        if (accept) begin
          state_d = (kind_in == qurt_pkg::KIND_TICK) ? S_TICK : S_MOD;
        end
      end
      S_MOD: begin
        st_we = 1'b1;
        if (pop_c) begin
          state_d = S_POP;
        end else begin
          state_d = S_IDLE;
          done_d = 1'b1;
          selected_d = sel_q;
          read_data_d = rdata_c;
          irq_lines_d = irq_c;
        end
      end
      S_POP: begin
        state_d = S_IDLE;
        done_d = 1'b1;
        selected_d = sel_q;
        read_data_d = fifo_rdata;
        irq_lines_d = 8'd0;
      end
      S_TICK: begin
        st_we = 1'b1;
        irq_acc_d = irq_acc_q | irq_c;
        if ({1'b0, unit_q} == (qurt_pkg::UNIT_W + 1)'(qurt_pkg::UNITS - 1)) begin
          state_d = S_IDLE;
          done_d = 1'b1;
          selected_d = 1'b0;
          read_data_d = 8'd0;
          irq_lines_d = irq_acc_q | irq_c;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    irq_acc_q <= irq_acc_d;
    selected_q <= selected_d;
    read_data_q <= read_data_d;
    irq_lines_q <= irq_lines_d;
    if (accept) begin
      kind_q <= kind_in;
      unit_q <= unit_in;
      ofs_q <= qurt_pkg::ofs_e'(addr_i[2:0]);
      wdata_q <= write_data_i;
      rxb_q <= rx_byte_i;
      sel_q <= sel_in;
    end else if (state_q == S_TICK) begin
      unit_q <= unit_q + 1'b1;
    end
  end

  assign done_o = done_q;
  assign selected_o = selected_q;
  assign read_data_o = read_data_q;
  assign irq_lines_o = irq_lines_q;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not raise busy");

  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  a_unsel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !selected_o |-> read_data_o == 8'd0)
    else $error("read data without a selected access");

  a_bus_no_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (kind_q == qurt_pkg::KIND_READ || kind_q == qurt_pkg::KIND_WRITE)
    |-> irq_lines_o == 8'd0)
    else $error("bus access raised an interrupt line");

  a_pop_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> $past(state_q) == S_MOD && kind_q == qurt_pkg::KIND_READ
    && ofs_q == qurt_pkg::OFS_DATA)
    else $error("FIFO pop outside a data read");
`endif

endmodule
